FILE: hdl/srps_pkg.sv
// ----------------------------------------------------------------------------
// srps_pkg
// Shared types, constants and helper functions of the servo ramp sequencer.
// ----------------------------------------------------------------------------
package srps_pkg;

	localparam int CHANNELS  = 8;
	localparam int FRAC_BITS = 16;
	localparam int NREPORT   = (CHANNELS < 8) ? CHANNELS : 8;
	localparam int DUTY_W    = 12;
	localparam int STEP_W    = DUTY_W + FRAC_BITS;
	localparam int STEPS_W   = 11;
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W    = $clog2(2 * CHANNELS);
	localparam int MTIME_W   = 15;
	localparam int DCNT_W    = $clog2(STEP_W + 1);

	localparam logic [15:0] SLOT_PERIOD_RST = 16'd2505;
	localparam logic [11:0] MIN_PULSE_RST   = 12'd500;
	localparam logic [11:0] MAX_PULSE_RST   = 12'd2500;
	localparam logic [15:0] TIME_MIN        = 16'd20;
	localparam logic [15:0] TIME_MAX        = 16'd30000;
	localparam logic [STEPS_W-1:0] STEPS_RST = STEPS_W'(2000 / 20);
	localparam logic [15:0] RECIP_5         = 16'hCCCD;

	localparam logic [1:0] KIND_MOVE  = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_SLOT  = 2'd2;

	localparam logic [1:0] RES_ACK  = 2'd0;
	localparam logic [1:0] RES_DUTY = 2'd1;
	localparam logic [1:0] RES_SLOT = 2'd2;

	localparam logic [1:0] REG_SLOT_PERIOD = 2'd0;
	localparam logic [1:0] REG_MIN_PULSE   = 2'd1;
	localparam logic [1:0] REG_MAX_PULSE   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT_ONE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_STEP_DEC,
		ST_DUTY_UPD,
		ST_REPORT
	} state_t;

	typedef enum logic [1:0] {
		OSEL_ACK,
		OSEL_DUTY,
		OSEL_SLOT
	} out_sel_t;

	typedef struct packed {
		logic     capture;
		logic     do_move;
		logic     ld_steps;
		logic     div_start;
		logic     div_store;
		logic     ch_clr;
		logic     ch_inc;
		logic     dec_steps;
		logic     upd_duty;
		logic     finish_ramp;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_last;
		logic     slot_adv;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       pending;
		logic       ramping;
		logic       div_done;
		logic       ch_last;
		logic       rpt_last;
		logic       out_free;
	} dp_stat_t;

	function automatic logic [DUTY_W-1:0] duty_rst(input int i);
		return (i == 1) ? DUTY_W'(1000) : DUTY_W'(1500);
	endfunction

	function automatic logic [DUTY_W-1:0] target_rst(input int i);
		logic [DUTY_W-1:0] v;
		v = duty_rst(i);
		if (i == 5)
			v = DUTY_W'(1550);
		return v;
	endfunction

endpackage

FILE: hdl/srps_div.sv
// ----------------------------------------------------------------------------
// srps_div
// Restoring divider, one quotient bit per cycle, for the ramp step size.
// ----------------------------------------------------------------------------
module srps_div import srps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [STEP_W-1:0]  dividend,
	input  logic [STEPS_W-1:0] divisor,
	output logic               done,
	output logic [STEP_W-1:0]  quotient
);

	logic [DCNT_W-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;
	logic [STEPS_W-1:0] rem_q;
	logic [STEP_W-1:0]  quo_q;
	logic [STEPS_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, quo_q[STEP_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DCNT_W'(STEP_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? STEPS_W'(trial - {1'b0, divisor}) : STEPS_W'(trial);
			quo_q <= {quo_q[STEP_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/srps_ctrl.sv
// ----------------------------------------------------------------------------
// srps_ctrl
// Sequencing state machine: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
module srps_ctrl import srps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
		ST_IDLE: begin
			if (in_valid)
				state_d = ST_DECODE;
		end
		ST_DECODE: begin
			case (stat.kind)
			KIND_MOVE, KIND_SLOT: state_d = ST_EMIT_ONE;
			KIND_FRAME: begin
				if (stat.pending)
					state_d = ST_DIV_START;
				else if (stat.ramping)
					state_d = ST_STEP_DEC;
				else
					state_d = ST_REPORT;
			end
			default: state_d = ST_IDLE;
			endcase
		end
		ST_EMIT_ONE: begin
			if (stat.out_free)
				state_d = ST_IDLE;
		end
		ST_DIV_START: state_d = ST_DIV_WAIT;
		ST_DIV_WAIT: begin
			if (stat.div_done)
				state_d = stat.ch_last ? ST_STEP_DEC : ST_DIV_START;
		end
		ST_STEP_DEC: state_d = ST_DUTY_UPD;
		ST_DUTY_UPD: begin
			if (stat.ch_last)
				state_d = ST_REPORT;
		end
		ST_REPORT: begin
			if (stat.out_free && stat.rpt_last)
				state_d = ST_IDLE;
		end
		default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.out_sel = OSEL_ACK;
		in_ready = 1'b0;
		case (state_q)
		ST_IDLE: begin
			in_ready    = 1'b1;
			cmd.capture = in_valid;
		end
		ST_DECODE: begin
			if (stat.kind == KIND_MOVE)
				cmd.do_move = 1'b1;
			if (stat.kind == KIND_FRAME) begin
				cmd.ch_clr   = 1'b1;
				cmd.ld_steps = stat.pending;
			end
		end
		ST_EMIT_ONE: begin
			cmd.out_load = stat.out_free;
			cmd.out_last = 1'b1;
			if (stat.kind == KIND_SLOT) begin
				cmd.out_sel  = OSEL_SLOT;
				cmd.slot_adv = stat.out_free;
			end
		end
		ST_DIV_START: cmd.div_start = 1'b1;
		ST_DIV_WAIT: begin
			if (stat.div_done) begin
				cmd.div_store = 1'b1;
				cmd.ch_inc    = !stat.ch_last;
			end
		end
		ST_STEP_DEC: begin
			cmd.dec_steps = 1'b1;
			cmd.ch_clr    = 1'b1;
		end
		ST_DUTY_UPD: begin
			cmd.upd_duty = 1'b1;
			if (stat.ch_last) begin
				cmd.finish_ramp = 1'b1;
				cmd.ch_clr      = 1'b1;
			end else begin
				cmd.ch_inc = 1'b1;
			end
		end
		ST_REPORT: begin
			cmd.out_sel = OSEL_DUTY;
			if (stat.out_free) begin
				cmd.out_load = 1'b1;
				cmd.out_last = stat.rpt_last;
				cmd.ch_inc   = !stat.rpt_last;
			end
		end
		default: ;
		endcase
	end

endmodule

FILE: hdl/srps_dp.sv
// ----------------------------------------------------------------------------
// srps_dp
// Datapath: channel state, step division, duty update and result register.
// ----------------------------------------------------------------------------
module srps_dp import srps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  kind,
	input  logic [3:0]  channel,
	input  logic [15:0] pulse_us,
	input  logic [15:0] move_time_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_type,
	output logic        accepted,
	output logic [2:0]  report_channel,
	output logic [11:0] duty_us,
	output logic [15:0] reload_value,
	output logic        pin_high,
	output logic        moving,
	output logic        last
);

	logic [15:0] slot_period_q;
	logic [11:0] min_pulse_q, max_pulse_q;

	logic [1:0]  kind_q;
	logic [3:0]  chan_q;
	logic [15:0] pulse_q, mtime_q;

	logic [DUTY_W-1:0]  cur_q [CHANNELS];
	logic [DUTY_W-1:0]  tgt_q [CHANNELS];
	logic [STEP_W-1:0]  stepm_q [CHANNELS];
	logic               stepn_q [CHANNELS];
	logic [STEPS_W-1:0] steps_tot_q, steps_left_q;
	logic               pending_q, ramping_q, busy_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CH_W-1:0]    idx_q;

	logic        ok;
	logic [15:0] mt_clamp;
	logic [28:0] recip_prod;
	logic [STEPS_W-1:0] steps_new;

	logic [DUTY_W-1:0] cur_i, tgt_i;
	logic [DUTY_W-1:0] diff_mag;
	logic              div_done;
	logic [STEP_W-1:0] quo;

	logic [STEP_W+STEPS_W-1:0] prod;
	logic [STEP_W+STEPS_W-FRAC_BITS-1:0] off;
	logic [DUTY_W-1:0] duty_new;

	logic [CH_W-1:0]   slot_ch;
	logic [DUTY_W-1:0] slot_duty;
	logic [15:0]       low_reload;
	logic              out_free;

	// Command check and move time to step count (t / 20 = (t / 4) * 0xCCCD >> 18).
	assign ok = (chan_q < 4'(CHANNELS)) && (pulse_q >= {4'd0, min_pulse_q})
		&& (pulse_q <= {4'd0, max_pulse_q});
	assign mt_clamp = (mtime_q < TIME_MIN) ? TIME_MIN :
		(mtime_q > TIME_MAX) ? TIME_MAX : mtime_q;
	assign recip_prod = 29'(mt_clamp[MTIME_W-1:2]) * 29'(RECIP_5);
	assign steps_new  = STEPS_W'(recip_prod >> 18);

	assign cur_i    = cur_q[idx_q];
	assign tgt_i    = tgt_q[idx_q];
	assign diff_mag = (cur_i > tgt_i) ? cur_i - tgt_i : tgt_i - cur_i;

	srps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({diff_mag, FRAC_BITS'(0)}),
		.divisor  (steps_left_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign prod = (STEP_W+STEPS_W)'(stepm_q[idx_q]) * (STEP_W+STEPS_W)'(steps_left_q);
	assign off  = prod[STEP_W+STEPS_W-1:FRAC_BITS];

	always_comb begin
		if (steps_left_q == '0)
			duty_new = tgt_i;
		else if (stepn_q[idx_q])
			duty_new = (off > ($bits(off))'(tgt_i)) ? '0 : DUTY_W'(($bits(off))'(tgt_i) - off);
		else if ((($bits(off)+1)'(tgt_i) + ($bits(off)+1)'(off)) > ($bits(off)+1)'({DUTY_W{1'b1}}))
			duty_new = {DUTY_W{1'b1}};
		else
			duty_new = DUTY_W'(tgt_i + off);
	end

	assign slot_ch    = slot_q[SLOT_W-1:1];
	assign slot_duty  = cur_q[slot_ch];
	assign low_reload = (slot_period_q >= 16'(slot_duty)) ? slot_period_q - 16'(slot_duty) : '0;
	assign out_free   = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_period_q <= SLOT_PERIOD_RST;
			min_pulse_q   <= MIN_PULSE_RST;
			max_pulse_q   <= MAX_PULSE_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i]   <= duty_rst(i);
				tgt_q[i]   <= target_rst(i);
				stepm_q[i] <= '0;
				stepn_q[i] <= 1'b0;
			end
			steps_tot_q  <= STEPS_RST;
			steps_left_q <= '0;
			pending_q    <= 1'b1;
			ramping_q    <= 1'b0;
			busy_q       <= 1'b0;
			slot_q       <= '0;
			idx_q        <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_SLOT_PERIOD: slot_period_q <= cfg_data;
				REG_MIN_PULSE:   min_pulse_q   <= cfg_data[11:0];
				REG_MAX_PULSE:   max_pulse_q   <= cfg_data[11:0];
				default: ;
				endcase
			end
			if (cmd.do_move && ok) begin
				tgt_q[chan_q[CH_W-1:0]] <= pulse_q[DUTY_W-1:0];
				steps_tot_q <= steps_new;
				pending_q   <= 1'b1;
				busy_q      <= 1'b1;
			end
			if (cmd.ld_steps) begin
				steps_left_q <= steps_tot_q;
				pending_q    <= 1'b0;
				ramping_q    <= 1'b1;
			end
			if (cmd.div_store) begin
				stepm_q[idx_q] <= quo;
				stepn_q[idx_q] <= cur_i < tgt_i;
			end
			if (cmd.dec_steps && steps_left_q != '0)
				steps_left_q <= steps_left_q - 1'b1;
			if (cmd.upd_duty)
				cur_q[idx_q] <= duty_new;
			if (cmd.finish_ramp && steps_left_q == '0) begin
				ramping_q <= 1'b0;
				busy_q    <= 1'b0;
			end
			if (cmd.slot_adv)
				slot_q <= (slot_q == SLOT_W'(2 * CHANNELS - 1)) ? '0 : slot_q + 1'b1;
			if (cmd.ch_clr)
				idx_q <= '0;
			else if (cmd.ch_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// Captured item and result payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			chan_q  <= channel;
			pulse_q <= pulse_us;
			mtime_q <= move_time_ms;
		end
		if (cmd.out_load) begin
			last   <= cmd.out_last;
			moving <= busy_q;
			case (cmd.out_sel)
			OSEL_DUTY: begin
				result_type    <= RES_DUTY;
				accepted       <= 1'b0;
				report_channel <= 3'(idx_q);
				duty_us        <= cur_i;
				reload_value   <= '0;
				pin_high       <= 1'b0;
			end
			OSEL_SLOT: begin
				result_type    <= RES_SLOT;
				accepted       <= 1'b0;
				report_channel <= 3'(slot_ch);
				duty_us        <= slot_duty;
				reload_value   <= slot_q[0] ? low_reload : 16'(slot_duty);
				pin_high       <= !slot_q[0];
			end
			default: begin
				result_type    <= RES_ACK;
				accepted       <= ok;
				report_channel <= '0;
				duty_us        <= '0;
				reload_value   <= '0;
				pin_high       <= 1'b0;
			end
			endcase
		end
	end

	assign stat.kind     = kind_q;
	assign stat.pending  = pending_q;
	assign stat.ramping  = ramping_q;
	assign stat.div_done = div_done;
	assign stat.ch_last  = idx_q == CH_W'(CHANNELS - 1);
	assign stat.rpt_last = idx_q == CH_W'(NREPORT - 1);
	assign stat.out_free = out_free;

endmodule

FILE: hdl/servo_ramp_pulse_sequencer_unit.sv
// A move command or slot tick gives a single result. A frame tick that recomputes the ramp
// runs a serial division (one quotient bit per cycle, one channel at a time), then the step
// count decrement, the duty update of each channel and eight duty reports; a plain ramp
// frame skips the division. One item is worked on at a time.
// Reset (arst_n low, asynchronous) restores the configuration registers and channel state at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// servo_ramp_pulse_sequencer_unit
// Eight-channel servo pulse sequencer with a linear speed ramp and slot timing.
// ----------------------------------------------------------------------------
module servo_ramp_pulse_sequencer_unit import srps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  channel,
	input  logic [15:0] pulse_us,
	input  logic [15:0] move_time_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_type,
	output logic        accepted,
	output logic [2:0]  report_channel,
	output logic [11:0] duty_us,
	output logic [15:0] reload_value,
	output logic        pin_high,
	output logic        moving,
	output logic        last
);

	// The controller sequences every item; the datapath holds the channel state and the
	// result register, so an input transfer can be taken while a result waits.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	srps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: the step size per channel is (|current - target| << FRAC_BITS) / steps,
	// and each frame the duty becomes target +/- (step * steps_left) >> FRAC_BITS.
	srps_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.channel        (channel),
		.pulse_us       (pulse_us),
		.move_time_ms   (move_time_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_type    (result_type),
		.accepted       (accepted),
		.report_channel (report_channel),
		.duty_us        (duty_us),
		.reload_value   (reload_value),
		.pin_high       (pin_high),
		.moving         (moving),
		.last           (last)
	);

	// Only an acknowledge can carry the accepted flag.
	a_acc_only_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_type != RES_ACK |-> !accepted)
		else $error("accepted set on a non-acknowledge result");

	// A high phase reloads the timer with the duty itself.
	a_high_reload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pin_high |-> reload_value == {4'd0, duty_us})
		else $error("high phase reload differs from duty");

	// Single-result items always mark their result as the last one.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_type != RES_DUTY |-> last)
		else $error("single result without last");

endmodule
